>>> src/dcm_pkg.sv
// shared constants, codes and control types of the motor speed controller
package dcm_pkg;

    localparam int DUTY_BITS  = 12;
    localparam int COUNT_BITS = 16;

    localparam int FUNC_W     = 3;
    localparam int TGT_W      = 12;
    localparam int GAIN_W     = 16;
    localparam int SUM_W      = 24;
    localparam int SPEED_W    = 16;
    localparam int ERR_W      = SPEED_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [DUTY_BITS-1:0] DUTY_MAX = '1;

    // duty per unit of speed, 2^DUTY_BITS / 100 in q8, rounded
    localparam int SCALE_Q8    = ((1 << DUTY_BITS) * 256 + 50) / 100;
    localparam int SCALE_BITS  = $clog2(SCALE_Q8 + 1);
    localparam int MPLIER_BITS = (SCALE_BITS > GAIN_W) ? SCALE_BITS : GAIN_W;
    localparam int MCNT_W      = $clog2(MPLIER_BITS);

    // pi sum before scaling stays below 2^40 in magnitude
    localparam int ACC_W = 41;
    localparam int MAC_W = ACC_W + SCALE_BITS;

    localparam logic [FUNC_W-1:0] FUNC_SET_TARGET = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ENC_EDGE   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RATE_TICK  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CTRL_UPD   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_STOP       = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 2'd2;

    typedef struct packed {
        logic start;
        logic set_acc;
    } t_mac_ctl;

    typedef struct packed {
        logic busy;
    } t_mac_sts;

endpackage

>>> src/dcm_mac.sv
// bit-serial multiply-accumulate unit, one multiplier bit per cycle
module dcm_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dcm_pkg::t_mac_ctl                 i_ctl,
    input  logic signed [dcm_pkg::MAC_W-1:0]  i_mcand,
    input  logic [dcm_pkg::MPLIER_BITS-1:0]   i_mplier,
    input  logic signed [dcm_pkg::MAC_W-1:0]  i_acc_init,
    output dcm_pkg::t_mac_sts                 o_sts,
    output logic signed [dcm_pkg::MAC_W-1:0]  o_acc
);
    import dcm_pkg::*;

    logic                     r_busy;
    logic [MCNT_W-1:0]        r_cnt;
    logic signed [MAC_W-1:0]  r_mcand;
    logic [MPLIER_BITS-1:0]   r_mplier;
    logic signed [MAC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == MCNT_W'(MPLIER_BITS - 1)) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_mcand  <= i_mcand;
            r_mplier <= i_mplier;
        end else if (r_busy) begin
            r_mcand  <= r_mcand <<< 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    // lsb first: the shifted multiplicand is added where the multiplier bit is set
    always_ff @(posedge i_clk) begin
        if (i_ctl.set_acc) begin
            r_acc <= i_acc_init;
        end else if (r_busy && r_mplier[0]) begin
            r_acc <= r_acc + r_mcand;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_acc      = r_acc;

endmodule

>>> src/dc_motor_pi_speed_controller.sv
// dc motor speed controller: event decode, encoder count, speed latch and pi duty update
//
//  channel   direction  handshake                  payload
//  event     in         i_valid / o_stall          i_func, i_target_value
//  result    out        o_valid / i_stall          o_duty, o_duty_written, o_line_a,
//                                                  o_line_b, o_measured_speed
//  config    in         i_cfg_wr_en                i_cfg_index, i_cfg_data
//
// one event at a time; encoder edge, rate tick, stop and zero target pass from S_EXEC
// straight to S_OUT, a non-zero target goes through S_SCALE first, and a control
// update goes through S_PROP, S_INTEG and S_SCALE, where the serial multiplier runs
// reset is synchronous and returns the state, counts, speed, duty, lines and gains to their reset values
// a stalled result holds its payload; no new request is taken until it is delivered
module dc_motor_pi_speed_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [dcm_pkg::FUNC_W-1:0]          i_func,
    input  logic signed [dcm_pkg::TGT_W-1:0]    i_target_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [dcm_pkg::DUTY_BITS-1:0]       o_duty,
    output logic                                o_duty_written,
    output logic                                o_line_a,
    output logic                                o_line_b,
    output logic [dcm_pkg::SPEED_W-1:0]         o_measured_speed,
    input  logic                                i_cfg_wr_en,
    input  logic [dcm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dcm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import dcm_pkg::*;

    localparam int CNT_EXT_W = 33;
    localparam int SUMX_W    = SUM_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PROP,
        S_INTEG,
        S_SCALE,
        S_OUT
    } t_state;

    t_state                  r_state;
    logic [FUNC_W-1:0]       r_in_func;
    logic signed [TGT_W-1:0] r_in_tgt;

    logic [GAIN_W-1:0]       r_prop_gain;
    logic [GAIN_W-1:0]       r_integ_gain;
    logic signed [SUM_W-1:0] r_integ_limit;

    logic signed [TGT_W-1:0] r_target;
    logic                    r_reverse;
    logic [COUNT_BITS-1:0]   r_edge_count;
    logic [COUNT_BITS-1:0]   r_prior_count;
    logic [SPEED_W-1:0]      r_speed;
    logic signed [SUM_W-1:0] r_error_sum;
    logic [DUTY_BITS-1:0]    r_duty;
    logic [1:0]              r_lines;
    logic                    r_written;

    logic [TGT_W-1:0]        w_in_mag;
    logic [TGT_W-1:0]        w_tgt_mag;
    logic signed [ERR_W-1:0] w_err;
    logic signed [SUMX_W-1:0] w_sum_ext;
    logic signed [SUM_W-1:0] w_sum_sat;
    logic [COUNT_BITS-1:0]   w_diff;
    logic [COUNT_BITS-1:0]   w_cmag;
    logic [CNT_EXT_W-1:0]    w_cmag_ext;
    logic [SPEED_W-1:0]      w_new_speed;
    logic [DUTY_BITS-1:0]    w_duty_tgt;
    logic [DUTY_BITS-1:0]    w_duty_pi;

    t_mac_ctl                w_mac_ctl;
    t_mac_sts                w_mac_sts;
    logic signed [MAC_W-1:0] w_mcand;
    logic [MPLIER_BITS-1:0]  w_mplier;
    logic signed [MAC_W-1:0] w_acc_init;
    logic signed [MAC_W-1:0] w_prod;

    dcm_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_mac_ctl),
        .i_mcand    (w_mcand),
        .i_mplier   (w_mplier),
        .i_acc_init (w_acc_init),
        .o_sts      (w_mac_sts),
        .o_acc      (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain   <= GAIN_W'(256);
            r_integ_gain  <= '0;
            r_integ_limit <= SUM_W'(8388607);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_PROP_GAIN:   r_prop_gain   <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN:  r_integ_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_LIMIT: r_integ_limit <= i_cfg_data[SUM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_in_mag  = r_in_tgt[TGT_W-1] ? TGT_W'(-r_in_tgt) : TGT_W'(r_in_tgt);
        w_tgt_mag = r_target[TGT_W-1] ? TGT_W'(-r_target) : TGT_W'(r_target);

        w_err = $signed({{(ERR_W-TGT_W){1'b0}}, w_tgt_mag}) - $signed({1'b0, r_speed});

        w_sum_ext = $signed({r_error_sum[SUM_W-1], r_error_sum})
                  + $signed({{(SUMX_W-ERR_W){w_err[ERR_W-1]}}, w_err});
        // clamp to the 24-bit signed range
        if (w_sum_ext[SUMX_W-1] != w_sum_ext[SUM_W-1]) begin
            w_sum_sat = w_sum_ext[SUMX_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                            : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            w_sum_sat = w_sum_ext[SUM_W-1:0];
        end

        w_diff      = r_edge_count - r_prior_count;
        w_cmag      = w_diff[COUNT_BITS-1] ? (~w_diff + 1'b1) : w_diff;
        w_cmag_ext  = CNT_EXT_W'(w_cmag);
        w_new_speed = (w_cmag_ext > CNT_EXT_W'(65535)) ? '1 : w_cmag_ext[SPEED_W-1:0];

        // target product is q8, never negative
        if (w_prod[MAC_W-1:8+DUTY_BITS] != '0) begin
            w_duty_tgt = DUTY_MAX;
        end else begin
            w_duty_tgt = w_prod[8+DUTY_BITS-1:8];
        end

        // pi product is q16; negative drives zero
        if (w_prod[MAC_W-1]) begin
            w_duty_pi = '0;
        end else if (w_prod[MAC_W-2:16+DUTY_BITS] != '0) begin
            w_duty_pi = DUTY_MAX;
        end else begin
            w_duty_pi = w_prod[16+DUTY_BITS-1:16];
        end
    end

    always_comb begin
        w_mac_ctl  = '0;
        w_mcand    = '0;
        w_mplier   = '0;
        w_acc_init = '0;
        unique case (r_state)
            S_EXEC: begin
                if (r_in_func == FUNC_SET_TARGET && r_in_tgt != '0) begin
                    w_mac_ctl.start   = 1'b1;
                    w_mac_ctl.set_acc = 1'b1;
                    w_mcand           = MAC_W'(w_in_mag);
                    w_mplier          = MPLIER_BITS'(SCALE_Q8);
                end else if (r_in_func == FUNC_CTRL_UPD) begin
                    w_mac_ctl.start   = 1'b1;
                    w_mac_ctl.set_acc = 1'b1;
                    w_acc_init        = MAC_W'({w_tgt_mag, 8'b0});
                    w_mcand           = {{(MAC_W-ERR_W){w_err[ERR_W-1]}}, w_err};
                    w_mplier          = MPLIER_BITS'(r_prop_gain);
                end
            end
            S_PROP: begin
                if (!w_mac_sts.busy) begin
                    w_mac_ctl.start = 1'b1;
                    w_mcand         = {{(MAC_W-SUM_W){r_error_sum[SUM_W-1]}}, r_error_sum};
                    w_mplier        = MPLIER_BITS'(r_integ_gain);
                end
            end
            S_INTEG: begin
                if (!w_mac_sts.busy) begin
                    w_mac_ctl.start   = 1'b1;
                    w_mac_ctl.set_acc = 1'b1;
                    w_mcand           = w_prod;
                    w_mplier          = MPLIER_BITS'(SCALE_Q8);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_target      <= '0;
            r_reverse     <= 1'b0;
            r_edge_count  <= '0;
            r_prior_count <= '0;
            r_speed       <= '0;
            r_error_sum   <= '0;
            r_duty        <= '0;
            r_lines       <= 2'b00;
            r_written     <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_in_func <= i_func;
                        r_in_tgt  <= i_target_value;
                        r_state   <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (r_in_func)
                        FUNC_SET_TARGET: begin
                            r_target  <= r_in_tgt;
                            r_written <= 1'b1;
                            if (r_in_tgt == '0) begin
                                r_duty  <= '0;
                                r_state <= S_OUT;
                            end else begin
                                r_reverse <= r_in_tgt[TGT_W-1];
                                // line a high for reverse, line b high for forward
                                r_lines   <= r_in_tgt[TGT_W-1] ? 2'b01 : 2'b10;
                                r_state   <= S_SCALE;
                            end
                        end
                        FUNC_ENC_EDGE: begin
                            r_written <= 1'b0;
                            r_state   <= S_OUT;
                            if (r_reverse) begin
                                r_edge_count <= r_edge_count + 1'b1;
                            end else begin
                                r_edge_count <= r_edge_count - 1'b1;
                            end
                        end
                        FUNC_RATE_TICK: begin
                            r_written     <= 1'b0;
                            r_state       <= S_OUT;
                            r_prior_count <= r_edge_count;
                            r_speed       <= w_new_speed;
                        end
                        FUNC_CTRL_UPD: begin
                            r_written <= 1'b1;
                            if (r_error_sum < r_integ_limit) begin
                                r_error_sum <= w_sum_sat;
                            end
                            r_state <= S_PROP;
                        end
                        FUNC_STOP: begin
                            r_written <= 1'b1;
                            r_lines   <= 2'b00;
                            r_duty    <= DUTY_MAX;
                            r_state   <= S_OUT;
                        end
                        default: begin
                            r_written <= 1'b0;
                            r_state   <= S_OUT;
                        end
                    endcase
                end
                S_PROP: begin
                    if (!w_mac_sts.busy) begin
                        r_state <= S_INTEG;
                    end
                end
                S_INTEG: begin
                    if (!w_mac_sts.busy) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    if (!w_mac_sts.busy) begin
                        r_duty  <= (r_in_func == FUNC_CTRL_UPD) ? w_duty_pi : w_duty_tgt;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = (r_state == S_OUT);
    assign o_duty           = r_duty;
    assign o_duty_written   = r_written;
    assign o_line_a         = r_lines[0];
    assign o_line_b         = r_lines[1];
    assign o_measured_speed = r_speed;

    a_no_request_while_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) o_valid |-> o_stall
    ) else $error("request taken while a result is pending");

    a_mac_only_in_pi_steps: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_mac_sts.busy |-> (r_state == S_PROP || r_state == S_INTEG || r_state == S_SCALE)
    ) else $error("multiplier running outside its steps");

    a_stop_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_in_func == FUNC_STOP)
            |-> (o_duty == DUTY_MAX && o_duty_written && !o_line_a && !o_line_b)
    ) else $error("stop result does not idle the lines at full duty");

    a_written_only_for_duty_events: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_duty_written)
            |-> (r_in_func == FUNC_SET_TARGET || r_in_func == FUNC_CTRL_UPD
                 || r_in_func == FUNC_STOP)
    ) else $error("duty flagged as written by an event that writes none");

endmodule
